// ===== hw/rtl/thp_pkg.sv =====
// Shared types, constants and register codes for the T/P/H compensation block.
// No dependencies; imported by thp_front, thp_back and the top level.
package thp_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CALIB   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_LAST   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_A        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_B        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_PRESENT  = 3'd6;

    localparam logic [15:0] HUM_DISABLED = 16'h8000;
    localparam logic [31:0] HUM_MAX      = 32'd419430400;

    typedef struct packed {
        logic [19:0] raw_t;
        logic [19:0] raw_p;
        logic [15:0] raw_h;
        logic        hum_en;
    } t_item;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
        logic [7:0]  h1;
        logic [15:0] h2;
        logic [7:0]  h3;
        logic [15:0] h4;
        logic [15:0] h5;
        logic [7:0]  h6;
        logic        hum_present;
    } t_calib;

endpackage

// ===== hw/rtl/thp_front.sv =====
// Front end: takes input words, flags whether humidity is to be computed,
// and queues them for the datapath. Depends on thp_pkg.
module thp_front import thp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_hum_present,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [55:0] i_data,
    output logic        o_valid,
    output t_item       o_item,
    input  logic        i_pop
);

    t_item                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wp;
    logic [QUEUE_AW-1:0]  r_rp;
    logic [QUEUE_AW:0]    r_cnt;
    logic                 push;
    logic                 pop;
    t_item                n_item;

    assign o_ready = (r_cnt != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;
    assign o_item  = r_mem[r_rp];

    always_comb begin
        n_item.raw_t  = i_data[19:0];
        n_item.raw_p  = i_data[39:20];
        n_item.raw_h  = i_data[55:40];
        n_item.hum_en = i_hum_present && (i_data[55:40] != HUM_DISABLED);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/thp_mul64.sv =====
// Two-stage 64x64 multiplier keeping the low 64 bits of the product,
// built from three 32x32 partial products. Depends on nothing.
module thp_mul64 (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_ll;
    logic [31:0] r_lh;
    logic [31:0] r_hl;
    logic [63:0] r_p;
    logic [63:0] ll;

    assign ll = {32'd0, i_a[31:0]} * {32'd0, i_b[31:0]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= ll;
            r_lh <= i_a[31:0] * i_b[63:32];
            r_hl <= i_a[63:32] * i_b[31:0];
            r_p  <= r_ll + {r_lh + r_hl, 32'd0};
        end
    end

    assign o_p = r_p;

endmodule

// ===== hw/rtl/thp_back.sv =====
// Back end: pipelined temperature, humidity and pressure datapath with a
// one-bit-per-stage divider. Depends on thp_pkg and thp_mul64.
module thp_back import thp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_calib      i_cal,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [18:0] o_temp,
    output logic [31:0] o_pres,
    output logic [6:0]  o_hum
);

    localparam int LAT  = 84;
    localparam int DIVN = 64;

    typedef struct packed {
        logic [19:0] adc_p;
        logic [15:0] adc_h;
        logic        hum_en;
        logic [18:0] temp;
    } t_side;

    typedef struct packed {
        logic [18:0] temp;
        logic [6:0]  hum;
    } t_ctx;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] dq;
        logic [63:0] den;
        logic        sg;
        logic        zr;
    } t_dstep;

    function automatic t_dstep div_step(input t_dstep s);
        t_dstep     d;
        logic [64:0] t;
        d    = s;
        t    = {s.rem, s.dq[63]};
        d.dq = {s.dq[62:0], 1'b0};
        if (t >= {1'b0, s.den}) begin
            t       = t - {1'b0, s.den};
            d.dq[0] = 1'b1;
        end
        d.rem = t[63:0];
        return d;
    endfunction

    logic            en;
    logic [LAT:1]    r_vld;
    t_side           r_side [1:11];
    t_ctx            r_ctx  [12:LAT];
    t_dstep          r_div  [0:DIVN];

    // sign/zero extended coefficients
    logic [31:0] t1x, t2x, t3x, h1x, h2x, h3x, h4x, h5x, h6x;
    logic [63:0] p1x, p2x, p3x, p4x, p5x, p6x, p7x, p8x, p9x;

    assign t1x = {16'd0, i_cal.t1};
    assign t2x = {{16{i_cal.t2[15]}}, i_cal.t2};
    assign t3x = {{16{i_cal.t3[15]}}, i_cal.t3};
    assign h1x = {24'd0, i_cal.h1};
    assign h2x = {{16{i_cal.h2[15]}}, i_cal.h2};
    assign h3x = {24'd0, i_cal.h3};
    assign h4x = {{16{i_cal.h4[15]}}, i_cal.h4};
    assign h5x = {{16{i_cal.h5[15]}}, i_cal.h5};
    assign h6x = {{24{i_cal.h6[7]}}, i_cal.h6};
    assign p1x = {48'd0, i_cal.p1};
    assign p2x = {{48{i_cal.p2[15]}}, i_cal.p2};
    assign p3x = {{48{i_cal.p3[15]}}, i_cal.p3};
    assign p4x = {{48{i_cal.p4[15]}}, i_cal.p4};
    assign p5x = {{48{i_cal.p5[15]}}, i_cal.p5};
    assign p6x = {{48{i_cal.p6[15]}}, i_cal.p6};
    assign p7x = {{48{i_cal.p7[15]}}, i_cal.p7};
    assign p8x = {{48{i_cal.p8[15]}}, i_cal.p8};
    assign p9x = {{48{i_cal.p9[15]}}, i_cal.p9};

    // stage registers
    logic [31:0] r1_u, r1_d, r2_ma, r2_dd, r3_a, r3_mb, r4_fine;
    logic [63:0] r5_x1;
    logic [31:0] r5_hx;
    logic [31:0] r6_mh5, r6_mx6, r6_mx3;
    logic [31:0] r7_left, r7_m, r8_mi, r8_left, r9_xx, r10_ss, r10_xx, r11_m1, r11_xx;
    logic [63:0] r8_x1p5, r8_x1p2, r9_x1p5, r9_x1p2, r10_x2, r10_x1b;
    logic [63:0] r_p [78:82];
    logic        r_zr [78:83];
    logic [63:0] r81_p8p, r82_p8p, r83_sum;
    logic [31:0] r84_pres;

    // combinational stage results
    logic [31:0] n_sdd, n_a, n_mb14, n_fine5, n_temp32;
    logic [31:0] n_left, n_a6, n_b3, n_inner, n_right, n_s, n_ss7, n_m14, n_hx;
    logic [6:0]  n_hum;
    logic [63:0] n_sqp3s, n_x1b, n_x2, n_fa, n_gn, n_den, n_num, n_q13;
    logic [63:0] n_j25, n_p8p19, n_p2s, n_p2, n_p3;
    t_dstep      n_div0;

    logic [63:0] m7_sq, m7_x1p5, m7_x1p2, m9_sqp6, m9_sqp3, m12_f, m12_g;
    logic [63:0] m80_qq, m80_p8p, m82_j;

    assign en    = !r_vld[LAT] || i_ready;
    assign o_pop = en && i_valid;

    always_comb begin
        n_sdd    = $signed(r2_dd) >>> 12;
        n_a      = $signed(r2_ma) >>> 11;
        n_mb14   = $signed(r3_mb) >>> 14;
        n_fine5  = r4_fine + {r4_fine[29:0], 2'b00} + 32'd128;
        n_temp32 = $signed(n_fine5) >>> 8;
        n_hx     = r4_fine - 32'd76800;

        n_left   = $signed(({16'd0, r_side[6].adc_h} << 14) - (h4x << 20) - r6_mh5
                           + 32'd16384) >>> 15;
        n_a6     = $signed(r6_mx6) >>> 10;
        n_b3     = $signed(r6_mx3) >>> 11;
        n_inner  = $signed(r7_m) >>> 10;
        n_right  = $signed(r8_mi + 32'd8192) >>> 14;
        n_s      = $signed(r9_xx) >>> 15;
        n_ss7    = $signed(r10_ss) >>> 7;
        n_m14    = r11_xx - 32'($signed(r11_m1) >>> 4);
        // clamp to 0..100 %
        if (n_m14[31]) begin
            n_hum = '0;
        end else if (n_m14 > HUM_MAX) begin
            n_hum = HUM_MAX[28:22];
        end else begin
            n_hum = n_m14[28:22];
        end
        if (!r_side[11].hum_en) begin
            n_hum = '0;
        end

        n_sqp3s = $signed(m9_sqp3) >>> 8;
        n_x1b   = n_sqp3s + (r9_x1p2 << 12);
        n_x2    = m9_sqp6 + (r9_x1p5 << 17) + (p4x << 35);
        n_fa    = (64'd1 << 47) + r10_x1b;
        n_gn    = ((64'd1048576 - {44'd0, r_side[10].adc_p}) << 31) - r10_x2;

        n_den   = $signed(m12_f) >>> 33;
        n_num   = m12_g;
        n_div0.rem = '0;
        n_div0.dq  = n_num[63] ? (64'd0 - n_num) : n_num;
        n_div0.den = n_den[63] ? (64'd0 - n_den) : n_den;
        n_div0.sg  = n_num[63] ^ n_den[63];
        n_div0.zr  = (n_den == '0);

        n_q13   = $signed(r_p[78]) >>> 13;
        n_j25   = $signed(m82_j) >>> 25;
        n_p8p19 = $signed(r82_p8p) >>> 19;
        n_p2s   = $signed(r83_sum) >>> 8;
        n_p2    = n_p2s + (p7x << 4);
        n_p3    = $signed(n_p2) >>> 8;
    end

    thp_mul64 u_mul_sq   (.i_clk, .i_en(en), .i_a(r5_x1), .i_b(r5_x1), .o_p(m7_sq));
    thp_mul64 u_mul_p5   (.i_clk, .i_en(en), .i_a(r5_x1), .i_b(p5x),   .o_p(m7_x1p5));
    thp_mul64 u_mul_p2   (.i_clk, .i_en(en), .i_a(r5_x1), .i_b(p2x),   .o_p(m7_x1p2));
    thp_mul64 u_mul_p6   (.i_clk, .i_en(en), .i_a(m7_sq), .i_b(p6x),   .o_p(m9_sqp6));
    thp_mul64 u_mul_p3   (.i_clk, .i_en(en), .i_a(m7_sq), .i_b(p3x),   .o_p(m9_sqp3));
    thp_mul64 u_mul_p1   (.i_clk, .i_en(en), .i_a(n_fa),  .i_b(p1x),   .o_p(m12_f));
    thp_mul64 u_mul_num  (.i_clk, .i_en(en), .i_a(n_gn),  .i_b(64'd3125), .o_p(m12_g));
    thp_mul64 u_mul_qq   (.i_clk, .i_en(en), .i_a(n_q13), .i_b(n_q13), .o_p(m80_qq));
    thp_mul64 u_mul_p8   (.i_clk, .i_en(en), .i_a(r_p[78]), .i_b(p8x), .o_p(m80_p8p));
    thp_mul64 u_mul_p9   (.i_clk, .i_en(en), .i_a(m80_qq), .i_b(p9x),  .o_p(m82_j));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // side data; temperature joins at stage 5
            r_side[1] <= '{adc_p: i_item.raw_p, adc_h: i_item.raw_h,
                           hum_en: i_item.hum_en, temp: '0};
            for (int k = 2; k <= 11; k++) begin
                if (k != 5) begin
                    r_side[k] <= r_side[k-1];
                end
            end
            r_side[5] <= '{adc_p: r_side[4].adc_p, adc_h: r_side[4].adc_h,
                           hum_en: r_side[4].hum_en, temp: n_temp32[18:0]};

            // temperature
            r1_u    <= {15'd0, i_item.raw_t[19:3]} - {15'd0, i_cal.t1, 1'b0};
            r1_d    <= {16'd0, i_item.raw_t[19:4]} - t1x;
            r2_ma   <= r1_u * t2x;
            r2_dd   <= r1_d * r1_d;
            r3_a    <= n_a;
            r3_mb   <= n_sdd * t3x;
            r4_fine <= r3_a + n_mb14;
            r5_x1   <= {{32{r4_fine[31]}}, r4_fine} - 64'd128000;
            r5_hx   <= n_hx;

            // humidity
            r6_mh5  <= h5x * r5_hx;
            r6_mx6  <= r5_hx * h6x;
            r6_mx3  <= r5_hx * h3x;
            r7_left <= n_left;
            r7_m    <= n_a6 * (n_b3 + 32'd32768);
            r8_left <= r7_left;
            r8_mi   <= (n_inner + 32'd2097152) * h2x;
            r9_xx   <= r8_left * n_right;
            r10_xx  <= r9_xx;
            r10_ss  <= n_s * n_s;
            r11_xx  <= r10_xx;
            r11_m1  <= n_ss7 * h1x;
            r_ctx[12] <= '{temp: r_side[11].temp, hum: n_hum};
            for (int k = 13; k <= LAT; k++) begin
                r_ctx[k] <= r_ctx[k-1];
            end

            // pressure
            r8_x1p5 <= m7_x1p5;
            r8_x1p2 <= m7_x1p2;
            r9_x1p5 <= r8_x1p5;
            r9_x1p2 <= r8_x1p2;
            r10_x2  <= n_x2;
            r10_x1b <= n_x1b;
            r_div[0] <= n_div0;
            for (int k = 1; k <= DIVN; k++) begin
                r_div[k] <= div_step(r_div[k-1]);
            end
            r_p[78]  <= r_div[DIVN].sg ? (64'd0 - r_div[DIVN].dq) : r_div[DIVN].dq;
            r_zr[78] <= r_div[DIVN].zr;
            for (int k = 79; k <= 82; k++) begin
                r_p[k] <= r_p[k-1];
            end
            for (int k = 79; k <= 83; k++) begin
                r_zr[k] <= r_zr[k-1];
            end
            r81_p8p  <= $signed(m80_p8p) >>> 0;
            r82_p8p  <= r81_p8p;
            r83_sum  <= r_p[82] + n_j25 + n_p8p19;
            r84_pres <= r_zr[83] ? 32'd0 : n_p3[31:0];
        end
    end

    assign o_valid = r_vld[LAT];
    assign o_temp  = r_ctx[LAT].temp;
    assign o_hum   = r_ctx[LAT].hum;
    assign o_pres  = r84_pres;

endmodule

// ===== hw/rtl/thp_sensor_compensation.sv =====
// Top level of the T/P/H compensation block: calibration registers, input queue
// and compensation pipeline. Depends on thp_pkg, thp_front, thp_back.
// Throughput: one word per cycle while the output is not stalled;
// the 64-stage divider is fully pipelined.
// A four-word input queue lets input be taken while the output is stalled.
// Reset (synchronous, active low) clears the calibration registers and all valid state.
module thp_sensor_compensation import thp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // raw_temperature[19:0], raw_pressure[39:20], raw_humidity[55:40]
    input  logic [55:0]           s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // temperature_centi[18:0], pressure_pa[50:19], humidity_percent[57:51], zero[63:58]
    output logic [63:0]           m_axis_tdata
);

    logic [47:0] r_temp_calib;
    logic [63:0] r_press_low;
    logic [63:0] r_press_high;
    logic [15:0] r_press_last;
    logic [31:0] r_hum_a;
    logic [39:0] r_hum_b;
    logic        r_hum_present;

    t_calib      cal;
    logic        q_valid;
    t_item       q_item;
    logic        q_pop;
    logic [18:0] temp;
    logic [31:0] pres;
    logic [6:0]  hum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_calib  <= '0;
            r_press_low   <= '0;
            r_press_high  <= '0;
            r_press_last  <= '0;
            r_hum_a       <= '0;
            r_hum_b       <= '0;
            r_hum_present <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TEMP_CALIB:  r_temp_calib  <= i_cfg_data[47:0];
                REG_PRESS_LOW:   r_press_low   <= i_cfg_data;
                REG_PRESS_HIGH:  r_press_high  <= i_cfg_data;
                REG_PRESS_LAST:  r_press_last  <= i_cfg_data[15:0];
                REG_HUM_A:       r_hum_a       <= i_cfg_data[31:0];
                REG_HUM_B:       r_hum_b       <= i_cfg_data[39:0];
                REG_HUM_PRESENT: r_hum_present <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cal.t1 = r_temp_calib[15:0];
        cal.t2 = r_temp_calib[31:16];
        cal.t3 = r_temp_calib[47:32];
        cal.p1 = r_press_low[15:0];
        cal.p2 = r_press_low[31:16];
        cal.p3 = r_press_low[47:32];
        cal.p4 = r_press_low[63:48];
        cal.p5 = r_press_high[15:0];
        cal.p6 = r_press_high[31:16];
        cal.p7 = r_press_high[47:32];
        cal.p8 = r_press_high[63:48];
        cal.p9 = r_press_last;
        cal.h1 = r_hum_a[7:0];
        cal.h2 = r_hum_a[23:8];
        cal.h3 = r_hum_a[31:24];
        cal.h4 = r_hum_b[15:0];
        cal.h5 = r_hum_b[31:16];
        cal.h6 = r_hum_b[39:32];
        cal.hum_present = r_hum_present;
    end

    thp_front u_front (
        .i_clk,
        .i_rst_n,
        .i_hum_present (r_hum_present),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_data        (s_axis_tdata),
        .o_valid       (q_valid),
        .o_item        (q_item),
        .i_pop         (q_pop)
    );

    thp_back u_back (
        .i_clk,
        .i_rst_n,
        .i_cal   (cal),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_temp  (temp),
        .o_pres  (pres),
        .o_hum   (hum)
    );

    assign m_axis_tdata = {6'd0, hum, pres, temp};

endmodule

// ===== hw/rtl/thp_sensor_compensation_chk.sv =====
// Port-level checker for the T/P/H compensation block, bound to the top level.
// Depends only on the clock, reset and stream ports of the top level.
module thp_sensor_compensation_chk (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [55:0]           s_axis_tdata,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [63:0]           m_axis_tdata
);

    // stalled result word must hold
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // waiting input word is held by the sender
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("input word changed while waiting");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[63:58] == 6'd0)
        else $error("output pad bits not zero");

    // humidity is clamped to 100 %
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[57:51] <= 7'd100)
        else $error("humidity above 100");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind thp_sensor_compensation thp_sensor_compensation_chk u_chk (.*);
